### src/lfsc_pkg.sv
`timescale 1ns / 1ps

package lfsc_pkg;

    // field widths
    localparam int MASK_W   = 8;
    localparam int POS_W    = 8;
    localparam int SPEED_W  = 12;
    localparam int TARGET_W = 11;
    localparam int DIST_W   = 32;
    localparam int GAIN_W   = 14;
    localparam int MM_W     = 16;
    localparam int THR_W    = 4;
    localparam int UM_W     = 26;
    localparam int CNT_W    = $clog2(MASK_W + 1);
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;
    localparam int TURN_W   = 2;

    // parameter defaults
    localparam int SENSOR_COUNT_DEF   = 8;
    localparam int DEBOUNCE_TICKS_DEF = 3;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_BASE_SPEED   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_KP           = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_KD           = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_B_DISTANCE   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_ARM_DISTANCE = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_BLACK_THR    = 3'd5;

    // register reset values
    localparam int BASE_SPEED_RST   = 600;
    localparam int KP_RST           = 60;
    localparam int KD_RST           = 100;
    localparam int B_DISTANCE_RST   = 1500;
    localparam int ARM_DISTANCE_RST = 11036;
    localparam int BLACK_THR_RST    = 6;
    localparam int UM_PER_MM        = 1000;

    // turn memory codes
    localparam logic [TURN_W-1:0] TURN_CENTRED = 2'd0;
    localparam logic [TURN_W-1:0] TURN_RIGHT   = 2'd1;
    localparam logic [TURN_W-1:0] TURN_LEFT    = 2'd2;

    // control constants
    localparam logic signed [POS_W-1:0] LINE_LOST = 8'sd127;
    localparam logic signed [POS_W-1:0] POS_MAX   = 8'sd100;
    localparam logic signed [POS_W-1:0] POS_MIN   = -8'sd100;
    localparam int DEADBAND     = 15;
    localparam int STEER_LIMIT  = 80;
    localparam int SEARCH_SPEED = 350;
    localparam int SEARCH_STEER = 200;
    localparam int TARGET_MAX   = 1200;
    localparam int ODO_SUM_MAX  = 2400;
    localparam int GAIN_SCALE   = 100;

    typedef struct packed {
        logic        [MASK_W-1:0]  sensor_mask;
        logic signed [POS_W-1:0]   line_position;
        logic signed [SPEED_W-1:0] right_speed;
        logic signed [SPEED_W-1:0] left_speed;
    } in_item_t;

    typedef struct packed {
        logic        [TARGET_W-1:0] right_target;
        logic        [TARGET_W-1:0] left_target;
        logic                       stopped_at_line;
        logic                       stop_armed;
        logic                       b_reached;
        logic        [DIST_W-1:0]   distance_um;
        logic signed [POS_W-1:0]    line_error;
    } out_item_t;

    typedef struct packed {
        logic        [TARGET_W-1:0] right_target;
        logic        [TARGET_W-1:0] left_target;
        logic signed [POS_W-1:0]    prev_error;
        logic        [TURN_W-1:0]   turn;
    } steer_res_t;

endpackage

### src/lfsc_steer.sv
`timescale 1ns / 1ps

module lfsc_steer (
    input  logic signed [lfsc_pkg::POS_W-1:0]    pos,
    input  logic signed [lfsc_pkg::POS_W-1:0]    prev_error,
    input  logic        [lfsc_pkg::GAIN_W-1:0]   kp,
    input  logic        [lfsc_pkg::GAIN_W-1:0]   kd,
    input  logic        [lfsc_pkg::TARGET_W-1:0] base_speed,
    output lfsc_pkg::steer_res_t                 res
);
    import lfsc_pkg::*;

    localparam int NUM_W    = 25;
    localparam int REM_W    = 13;
    localparam int Q_W      = 7;
    localparam int SUM_W    = TARGET_W + 1;
    localparam int PROD_W   = REM_W + 13;
    localparam int RECIP_SH = PROD_W - Q_W;
    localparam logic [NUM_W-1:0]  CAP_NUM = NUM_W'(STEER_LIMIT * GAIN_SCALE);
    localparam logic [PROD_W-1:0] RECIP   =
        PROD_W'(((1 << RECIP_SH) + GAIN_SCALE - 1) / GAIN_SCALE);

    logic        [POS_W-1:0]  mag;
    logic                     in_deadband;
    logic signed [POS_W:0]    diff;
    logic signed [NUM_W-1:0]  p_term;
    logic signed [NUM_W-1:0]  d_term;
    logic signed [NUM_W-1:0]  num;
    logic                     num_neg;
    logic        [NUM_W-1:0]  abs_num;
    logic        [PROD_W-1:0] prod;
    logic        [Q_W-1:0]    quot;
    logic        [Q_W-1:0]    mq;
    logic                     steer_left;
    logic                     steer_right;
    logic        [Q_W-1:0]    steer_mag;
    logic signed [SUM_W-1:0]  rt_s;
    logic        [SUM_W-1:0]  lt_u;

    assign mag         = pos[POS_W-1] ? POS_W'(-pos) : POS_W'(pos);
    assign in_deadband = mag <= POS_W'(DEADBAND);
    assign diff        = {pos[POS_W-1], pos} - {prev_error[POS_W-1], prev_error};
    assign p_term      = NUM_W'($signed({1'b0, kp})) * NUM_W'(pos);
    assign d_term      = NUM_W'($signed({1'b0, kd})) * NUM_W'(diff);
    assign num         = p_term + d_term;
    assign num_neg     = num[NUM_W-1];
    assign abs_num     = num_neg ? NUM_W'(-num) : NUM_W'(num);

    // reciprocal multiply by the gain scale, exact below the clamp point
    assign prod = PROD_W'(abs_num[REM_W-1:0]) * RECIP;
    assign quot = prod[RECIP_SH +: Q_W];

    assign mq          = (abs_num >= CAP_NUM) ? Q_W'(STEER_LIMIT) : quot;
    assign steer_left  = !num_neg && (mq != '0);
    assign steer_right = num_neg && (mq != '0);

    // right-hand steer (negative sum) is suppressed on the targets
    assign steer_mag = (!in_deadband && steer_left) ? mq : '0;
    assign rt_s      = $signed({1'b0, base_speed}) - $signed(SUM_W'(steer_mag));
    assign lt_u      = SUM_W'(base_speed) + SUM_W'(steer_mag);

    always_comb begin
        if (rt_s[SUM_W-1]) begin
            res.right_target = '0;
        end else if (rt_s > $signed(SUM_W'(TARGET_MAX))) begin
            res.right_target = TARGET_W'(TARGET_MAX);
        end else begin
            res.right_target = rt_s[TARGET_W-1:0];
        end
        if (lt_u > SUM_W'(TARGET_MAX)) begin
            res.left_target = TARGET_W'(TARGET_MAX);
        end else begin
            res.left_target = lt_u[TARGET_W-1:0];
        end
        if (in_deadband) begin
            res.prev_error = '0;
            res.turn       = TURN_CENTRED;
        end else begin
            res.prev_error = pos;
            if (steer_left) begin
                res.turn = TURN_LEFT;
            end else if (steer_right) begin
                res.turn = TURN_RIGHT;
            end else begin
                res.turn = TURN_CENTRED;
            end
        end
    end

endmodule

### src/line_follow_steering_controller.sv
// pipeline: a result passes the input register, then the result register
// throughput: one transaction per clock while the result side does not stall
// reset: aresetn low at a rising edge clears all tracking state and both
// pipeline valids and restores the register defaults; no clearing pass
`timescale 1ns / 1ps

module line_follow_steering_controller #(
    parameter int SENSOR_COUNT   = lfsc_pkg::SENSOR_COUNT_DEF,
    parameter int DEBOUNCE_TICKS = lfsc_pkg::DEBOUNCE_TICKS_DEF
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  lfsc_pkg::in_item_t                  s_data,
    output logic                                m_valid,
    input  logic                                m_ready,
    output lfsc_pkg::out_item_t                 m_data,
    input  logic                                cfg_wr_en,
    input  logic [lfsc_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [lfsc_pkg::CFG_DATA_W-1:0]     cfg_wdata
);
    import lfsc_pkg::*;

    localparam int COUNTED = (SENSOR_COUNT < MASK_W) ? SENSOR_COUNT : MASK_W;
    localparam int DEB_W   = $clog2(DEBOUNCE_TICKS + 1);
    localparam int ODO_W   = DIST_W + 1;
    localparam int INC_W   = SPEED_W + 5;
    localparam int SUM_W   = SPEED_W + 1;

    // pipeline registers
    logic       in_valid_reg;
    in_item_t   in_data_reg;
    logic       m_valid_reg;
    out_item_t  m_data_reg;
    logic       advance;

    // configuration
    logic [TARGET_W-1:0] base_speed_reg;
    logic [GAIN_W-1:0]   kp_reg;
    logic [GAIN_W-1:0]   kd_reg;
    logic [UM_W-1:0]     b_um_reg;
    logic [UM_W-1:0]     arm_um_reg;
    logic [THR_W-1:0]    thr_reg;

    // tracking state
    logic [DIST_W-1:0]       travel_reg, travel_next;
    logic signed [POS_W-1:0] prev_err_reg, prev_err_next;
    logic [TURN_W-1:0]       turn_reg, turn_next;
    logic                    seen_reg, seen_next;
    logic                    armed_reg, armed_next;
    logic [DEB_W-1:0]        deb_reg, deb_next;
    logic                    stop_reg, stop_next;
    logic                    b_flag_reg, b_flag_next;

    logic                    lost;
    logic signed [POS_W-1:0] pos_sat;
    logic signed [POS_W-1:0] err_out;
    logic [SPEED_W-1:0]      rs_mag, ls_mag;
    logic [SUM_W-1:0]        speed_sum;
    logic [INC_W-1:0]        odo_inc;
    logic [ODO_W-1:0]        odo_sum;
    logic [CNT_W-1:0]        dark_cnt;
    logic                    stop_seen;
    steer_res_t              steer_res;
    out_item_t               res;

    assign advance = in_valid_reg && (!m_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || advance;
    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    assign lost    = in_data_reg.line_position == LINE_LOST;
    assign pos_sat = (in_data_reg.line_position > POS_MAX) ? POS_MAX :
                     (in_data_reg.line_position < POS_MIN) ? POS_MIN :
                     in_data_reg.line_position;
    assign err_out = lost ? '0 : pos_sat;

    // odometry: sum of speeds times 15 um per tick
    assign rs_mag = in_data_reg.right_speed[SPEED_W-1] ? SPEED_W'(-in_data_reg.right_speed)
                                                       : SPEED_W'(in_data_reg.right_speed);
    assign ls_mag = in_data_reg.left_speed[SPEED_W-1] ? SPEED_W'(-in_data_reg.left_speed)
                                                      : SPEED_W'(in_data_reg.left_speed);
    assign speed_sum = SUM_W'(rs_mag) + SUM_W'(ls_mag);
    assign odo_inc   = INC_W'({speed_sum, 4'b0000}) - INC_W'(speed_sum);
    assign odo_sum   = ODO_W'(travel_reg) + ODO_W'(odo_inc);

    always_comb begin
        if (speed_sum > SUM_W'(ODO_SUM_MAX)) begin
            travel_next = travel_reg;
        end else if (odo_sum[ODO_W-1]) begin
            travel_next = '1;
        end else begin
            travel_next = odo_sum[DIST_W-1:0];
        end
    end

    assign armed_next = armed_reg || (travel_next >= DIST_W'(arm_um_reg));

    always_comb begin
        dark_cnt = '0;
        for (int i = 0; i < MASK_W; i++) begin
            if (i < COUNTED && in_data_reg.sensor_mask[i]) begin
                dark_cnt = dark_cnt + 1'b1;
            end
        end
    end

    // stop line debounce
    always_comb begin
        deb_next  = deb_reg;
        stop_next = stop_reg;
        stop_seen = CNT_W'(thr_reg) <= dark_cnt;
        if (!stop_reg) begin
            if (!armed_next) begin
                deb_next = '0;
            end else begin
                if (stop_seen) begin
                    if (deb_reg < DEB_W'(DEBOUNCE_TICKS)) begin
                        deb_next = deb_reg + 1'b1;
                    end
                end else begin
                    deb_next = '0;
                end
                if (deb_next >= DEB_W'(DEBOUNCE_TICKS)) begin
                    stop_next = 1'b1;
                end
            end
        end
    end

    lfsc_steer u_steer (
        .pos        (pos_sat),
        .prev_error (prev_err_reg),
        .kp         (kp_reg),
        .kd         (kd_reg),
        .base_speed (base_speed_reg),
        .res        (steer_res)
    );

    always_comb begin
        b_flag_next       = b_flag_reg;
        prev_err_next     = prev_err_reg;
        turn_next         = turn_reg;
        seen_next         = seen_reg;
        res.right_target  = '0;
        res.left_target   = '0;
        if (!stop_next) begin
            if (travel_next >= DIST_W'(b_um_reg)) begin
                b_flag_next = 1'b1;
            end
            if (lost) begin
                if (seen_reg) begin
                    case (turn_reg)
                        TURN_LEFT: begin
                            res.right_target = TARGET_W'(SEARCH_SPEED + SEARCH_STEER);
                            res.left_target  = TARGET_W'(SEARCH_SPEED - SEARCH_STEER);
                        end
                        TURN_RIGHT: begin
                            res.right_target = TARGET_W'(SEARCH_SPEED - SEARCH_STEER);
                            res.left_target  = TARGET_W'(SEARCH_SPEED + SEARCH_STEER);
                        end
                        default: begin
                            res.right_target = TARGET_W'(SEARCH_SPEED);
                            res.left_target  = TARGET_W'(SEARCH_SPEED);
                        end
                    endcase
                end
            end else begin
                seen_next        = 1'b1;
                prev_err_next    = steer_res.prev_error;
                turn_next        = steer_res.turn;
                res.right_target = steer_res.right_target;
                res.left_target  = steer_res.left_target;
            end
        end
        res.stopped_at_line = stop_next;
        res.stop_armed      = armed_next;
        res.b_reached       = b_flag_next;
        res.distance_um     = travel_next;
        res.line_error      = err_out;
    end

    // pipeline control
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            if (s_valid && s_ready) begin
                in_valid_reg <= 1'b1;
            end else if (advance) begin
                in_valid_reg <= 1'b0;
            end
            if (advance) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_data_reg <= s_data;
        end
        if (advance) begin
            m_data_reg <= res;
        end
    end

    // configuration and tracking state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            base_speed_reg <= TARGET_W'(BASE_SPEED_RST);
            kp_reg         <= GAIN_W'(KP_RST);
            kd_reg         <= GAIN_W'(KD_RST);
            b_um_reg       <= UM_W'(B_DISTANCE_RST * UM_PER_MM);
            arm_um_reg     <= UM_W'(ARM_DISTANCE_RST * UM_PER_MM);
            thr_reg        <= THR_W'(BLACK_THR_RST);
            travel_reg     <= '0;
            prev_err_reg   <= '0;
            turn_reg       <= TURN_CENTRED;
            seen_reg       <= 1'b0;
            armed_reg      <= 1'b0;
            deb_reg        <= '0;
            stop_reg       <= 1'b0;
            b_flag_reg     <= 1'b0;
        end else begin
            if (advance) begin
                travel_reg   <= travel_next;
                prev_err_reg <= prev_err_next;
                turn_reg     <= turn_next;
                seen_reg     <= seen_next;
                armed_reg    <= armed_next;
                deb_reg      <= deb_next;
                stop_reg     <= stop_next;
            end
            // a write of the B distance clears the flag
            if (cfg_wr_en && (cfg_index == REG_B_DISTANCE)) begin
                b_flag_reg <= 1'b0;
            end else if (advance) begin
                b_flag_reg <= b_flag_next;
            end
            if (cfg_wr_en) begin
                case (cfg_index)
                    REG_BASE_SPEED:   base_speed_reg <= cfg_wdata[TARGET_W-1:0];
                    REG_KP:           kp_reg         <= cfg_wdata[GAIN_W-1:0];
                    REG_KD:           kd_reg         <= cfg_wdata[GAIN_W-1:0];
                    REG_B_DISTANCE: begin
                        // millimetres held pre-scaled to micrometres
                        b_um_reg <= UM_W'(cfg_wdata[MM_W-1:0]) * UM_W'(UM_PER_MM);
                    end
                    REG_ARM_DISTANCE: begin
                        arm_um_reg <= UM_W'(cfg_wdata[MM_W-1:0]) * UM_W'(UM_PER_MM);
                    end
                    REG_BLACK_THR:    thr_reg        <= cfg_wdata[THR_W-1:0];
                    default: begin
                    end
                endcase
            end
        end
    end

endmodule

### src/lfsc_checker.sv
`timescale 1ns / 1ps

module lfsc_assertions (
    input logic                aclk,
    input logic                aresetn,
    input logic                m_valid,
    input logic                m_ready,
    input lfsc_pkg::out_item_t m_data
);
    import lfsc_pkg::*;

    logic              stop_seen_reg;
    logic              have_last_reg;
    logic [DIST_W-1:0] last_dist_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            stop_seen_reg <= 1'b0;
            have_last_reg <= 1'b0;
        end else if (m_valid && m_ready) begin
            have_last_reg <= 1'b1;
            if (m_data.stopped_at_line) begin
                stop_seen_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (m_valid && m_ready) begin
            last_dist_reg <= m_data.distance_um;
        end
    end

    // a stalled result transaction holds
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("result changed while stalled");

    // the stop is permanent
    a_stop_sticky: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && stop_seen_reg |-> m_data.stopped_at_line)
        else $error("stop released");

    a_stop_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.stopped_at_line |->
            m_data.right_target == '0 && m_data.left_target == '0 && m_data.stop_armed)
        else $error("stopped with targets or unarmed");

    a_dist_mono: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && have_last_reg |-> m_data.distance_um >= last_dist_reg)
        else $error("distance went backwards");

    a_target_max: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_data.right_target <= TARGET_W'(TARGET_MAX) &&
                    m_data.left_target <= TARGET_W'(TARGET_MAX))
        else $error("target above limit");

endmodule

bind line_follow_steering_controller lfsc_assertions u_lfsc_assertions (
    .aclk    (aclk),
    .aresetn (aresetn),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_data  (m_data)
);

### bench/lfsc_checker.sv
`timescale 1ns / 1ps

module lfsc_checker (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_valid,
    input  logic                            s_ready,
    input  lfsc_pkg::in_item_t              s_data,
    input  logic                            m_valid,
    input  logic                            m_ready,
    input  lfsc_pkg::out_item_t             m_data,
    input  logic                            cfg_wr_en,
    input  logic [lfsc_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [lfsc_pkg::CFG_DATA_W-1:0] cfg_wdata,
    output int                              mismatches,
    output int                              in_flight
);
    import lfsc_pkg::*;

    // mean wheel speed over a 30 ms tick, in um per mm/s of summed speed
    localparam int UM_PER_SPEED_SUM = 15;

    logic [TARGET_W-1:0] cfg_base;
    logic [GAIN_W-1:0]   cfg_kp;
    logic [GAIN_W-1:0]   cfg_kd;
    logic [MM_W-1:0]     cfg_b;
    logic [MM_W-1:0]     cfg_arm;
    logic [THR_W-1:0]    cfg_thr;

    logic [DIST_W-1:0]   odo_um;
    int                  last_err;
    logic [TURN_W-1:0]   turn_dir;
    bit                  line_seen;
    bit                  armed;
    int                  dark_run;
    bit                  halted;
    bit                  b_hit;

    out_item_t           pending_cmds[$];
    int                  result_idx;

    initial mismatches = 0;

    task automatic report_mismatch(input string what);
        mismatches++;
        $display("%0t ns: result %0d mismatch:%s", $time, result_idx, what);
    endtask

    function automatic string field_diff(input string name, input logic signed [63:0] got,
                                         input logic signed [63:0] want);
        if (got === want)
            return "";
        return $sformatf(" %s got %0d want %0d", name, got, want);
    endfunction

    function automatic logic [TARGET_W-1:0] clamp_speed(input int v);
        if (v < 0)
            return '0;
        if (v > TARGET_MAX)
            return TARGET_W'(TARGET_MAX);
        return v[TARGET_W-1:0];
    endfunction

    // one control tick: odometry, arming, stop line debounce, then steering
    function automatic out_item_t compute_tick(input in_item_t x);
        out_item_t r;
        int        pos;
        int        rs;
        int        ls;
        int        mag;
        int        num;
        int        steer;
        int        rt;
        int        lt;
        int        err_used;
        longint    acc;
        bit        lost;
        pos = int'(x.line_position);
        rs = int'(x.right_speed);
        ls = int'(x.left_speed);
        lost = (pos == LINE_LOST);
        err_used = 0;
        rt = 0;
        lt = 0;
        if (!lost) begin
            if (pos > POS_MAX)
                pos = int'(POS_MAX);
            if (pos < POS_MIN)
                pos = int'(POS_MIN);
            err_used = pos;
        end

        if (rs < 0)
            rs = -rs;
        if (ls < 0)
            ls = -ls;
        // overspeed ticks are treated as wheel slip and add nothing
        if (rs + ls <= ODO_SUM_MAX) begin
            acc = longint'(odo_um) + longint'((rs + ls) * UM_PER_SPEED_SUM);
            odo_um = (acc > 64'd4294967295) ? '1 : acc[DIST_W-1:0];
        end
        if (longint'(odo_um) >= longint'(cfg_arm) * UM_PER_MM)
            armed = 1'b1;

        if (!halted) begin
            if (!armed) begin
                dark_run = 0;
            end else begin
                if ($countones(x.sensor_mask) >= cfg_thr) begin
                    if (dark_run < DEBOUNCE_TICKS_DEF)
                        dark_run++;
                end else begin
                    dark_run = 0;
                end
                if (dark_run >= DEBOUNCE_TICKS_DEF)
                    halted = 1'b1;
            end
        end

        if (!halted) begin
            if (!b_hit && longint'(odo_um) >= longint'(cfg_b) * UM_PER_MM)
                b_hit = 1'b1;
            if (lost) begin
                if (line_seen) begin
                    case (turn_dir)
                        TURN_LEFT: begin
                            rt = SEARCH_SPEED + SEARCH_STEER;
                            lt = SEARCH_SPEED - SEARCH_STEER;
                        end
                        TURN_RIGHT: begin
                            rt = SEARCH_SPEED - SEARCH_STEER;
                            lt = SEARCH_SPEED + SEARCH_STEER;
                        end
                        default: begin
                            rt = SEARCH_SPEED;
                            lt = SEARCH_SPEED;
                        end
                    endcase
                end
            end else begin
                steer = 0;
                line_seen = 1'b1;
                mag = (pos < 0) ? -pos : pos;
                if (mag <= DEADBAND) begin
                    last_err = 0;
                    turn_dir = TURN_CENTRED;
                end else begin
                    num = int'(cfg_kp) * pos + int'(cfg_kd) * (pos - last_err);
                    steer = -(num / GAIN_SCALE);
                    if (steer > STEER_LIMIT)
                        steer = STEER_LIMIT;
                    if (steer < -STEER_LIMIT)
                        steer = -STEER_LIMIT;
                    last_err = pos;
                    turn_dir = (steer > 0) ? TURN_RIGHT : ((steer < 0) ? TURN_LEFT : TURN_CENTRED);
                end
                // right turns are suppressed, the memory above still sees them
                if (steer > 0)
                    steer = 0;
                rt = int'(cfg_base) + steer;
                lt = int'(cfg_base) - steer;
            end
        end

        r.right_target = clamp_speed(rt);
        r.left_target = clamp_speed(lt);
        r.stopped_at_line = halted;
        r.stop_armed = armed;
        r.b_reached = b_hit;
        r.distance_um = odo_um;
        r.line_error = err_used[POS_W-1:0];
        return r;
    endfunction

    always @(posedge aclk) begin : watch
        out_item_t want;
        string     diffs;
        if (!aresetn) begin
            cfg_base = TARGET_W'(BASE_SPEED_RST);
            cfg_kp = GAIN_W'(KP_RST);
            cfg_kd = GAIN_W'(KD_RST);
            cfg_b = MM_W'(B_DISTANCE_RST);
            cfg_arm = MM_W'(ARM_DISTANCE_RST);
            cfg_thr = THR_W'(BLACK_THR_RST);
            odo_um = '0;
            last_err = 0;
            turn_dir = TURN_CENTRED;
            line_seen = 1'b0;
            armed = 1'b0;
            dark_run = 0;
            halted = 1'b0;
            b_hit = 1'b0;
            result_idx = 0;
            pending_cmds.delete();
            in_flight <= 0;
        end else begin
            if (cfg_wr_en) begin
                case (cfg_index)
                    REG_BASE_SPEED:   cfg_base = cfg_wdata[TARGET_W-1:0];
                    REG_KP:           cfg_kp = cfg_wdata[GAIN_W-1:0];
                    REG_KD:           cfg_kd = cfg_wdata[GAIN_W-1:0];
                    REG_B_DISTANCE: begin
                        cfg_b = cfg_wdata[MM_W-1:0];
                        b_hit = 1'b0;
                    end
                    REG_ARM_DISTANCE: cfg_arm = cfg_wdata[MM_W-1:0];
                    REG_BLACK_THR:    cfg_thr = cfg_wdata[THR_W-1:0];
                    default: ;
                endcase
            end

            if (m_valid && m_ready) begin
                if (pending_cmds.size() == 0) begin
                    report_mismatch(" result with nothing expected");
                end else begin
                    want = pending_cmds.pop_front();
                    diffs = {field_diff("right_target", m_data.right_target, want.right_target),
                             field_diff("left_target", m_data.left_target, want.left_target),
                             field_diff("stopped_at_line", m_data.stopped_at_line,
                                        want.stopped_at_line),
                             field_diff("stop_armed", m_data.stop_armed, want.stop_armed),
                             field_diff("b_reached", m_data.b_reached, want.b_reached),
                             field_diff("distance_um", m_data.distance_um, want.distance_um),
                             field_diff("line_error", $signed(m_data.line_error),
                                        $signed(want.line_error))};
                    if (diffs != "")
                        report_mismatch(diffs);
                end
                result_idx++;
            end

            if (s_valid && s_ready)
                pending_cmds.push_back(compute_tick(s_data));
            in_flight <= pending_cmds.size();
        end
    end

endmodule

### bench/tb.sv
`timescale 1ns / 1ps

module tb;
    import lfsc_pkg::*;

    // indexes beyond the register list, written only to see them ignored
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_A = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_B = 3'd7;
    localparam int WIDE_DARK = 6;

    logic                  aclk;
    logic                  aresetn;
    logic                  s_valid;
    logic                  s_ready;
    in_item_t              s_data;
    logic                  m_valid;
    logic                  m_ready;
    out_item_t             m_data;
    logic                  cfg_wr_en;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_wdata;
    int                    mismatches;
    int                    in_flight;

    bit tx_burst;
    bit rx_burst;
    int rx_count;
    int dark_streak;

    line_follow_steering_controller u_top (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    lfsc_checker u_chk (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_data     (s_data),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_data     (m_data),
        .cfg_wr_en  (cfg_wr_en),
        .cfg_index  (cfg_index),
        .cfg_wdata  (cfg_wdata),
        .mismatches (mismatches),
        .in_flight  (in_flight)
    );

    initial begin
        aclk = 1'b0;
        forever #1 aclk = ~aclk;
    end

    initial begin
        #400_000;
        $display("line_follow_steering_controller regression: fail");
        $finish;
    end

    // result side: random stalls, bursts of none, and one long hold-off
    initial begin : result_sink
        int hold;
        m_ready <= 1'b0;
        rx_count = 0;
        do @(posedge aclk); while (!aresetn);
        forever begin
            if ($urandom_range(0, 31) == 0)
                rx_burst = !rx_burst;
            hold = rx_burst ? 0 : $urandom_range(0, 14);
            if (rx_count == 150)
                hold = 250;
            if (hold > 0) begin
                m_ready <= 1'b0;
                repeat (hold) @(posedge aclk);
            end
            m_ready <= 1'b1;
            do @(posedge aclk); while (!m_valid);
            rx_count++;
        end
    end

    function automatic in_item_t make_tick(input logic [MASK_W-1:0] mask, input int pos,
                                           input int rs, input int ls);
        in_item_t x;
        x.sensor_mask = mask;
        x.line_position = pos[POS_W-1:0];
        x.right_speed = rs[SPEED_W-1:0];
        x.left_speed = ls[SPEED_W-1:0];
        return x;
    endfunction

    // narrow masks look like a line under the sensor bar, wide ones like a stop line
    function automatic in_item_t random_tick(input bit wide, input bit allow_noise);
        in_item_t x;
        int       pick;
        if (wide) begin
            x.sensor_mask = '1;
            repeat ($urandom_range(0, 2)) x.sensor_mask[$urandom_range(0, MASK_W - 1)] = 1'b0;
        end else if (allow_noise && $urandom_range(0, 9) == 0) begin
            x.sensor_mask = MASK_W'($urandom);
        end else begin
            x.sensor_mask = MASK_W'(((1 << $urandom_range(1, 3)) - 1)
                                    << $urandom_range(0, MASK_W - 1));
        end
        pick = $urandom_range(0, 99);
        if (pick < 12)
            x.line_position = LINE_LOST;
        else if (pick < 27)
            x.line_position = POS_W'(int'($urandom_range(0, 2 * DEADBAND)) - DEADBAND);
        else if (pick < 31)
            x.line_position = POS_W'($urandom_range(101, 126));
        else if (pick < 35)
            x.line_position = POS_W'(-int'($urandom_range(101, 128)));
        else
            x.line_position = POS_W'(int'($urandom_range(0, 200)) - 100);
        x.right_speed = ($urandom_range(0, 6) == 0) ? SPEED_W'($urandom)
                                                    : SPEED_W'(int'($urandom_range(0, 2400)) - 1200);
        x.left_speed = ($urandom_range(0, 6) == 0) ? SPEED_W'($urandom)
                                                   : SPEED_W'(int'($urandom_range(0, 2400)) - 1200);
        return x;
    endfunction

    task automatic send_tick(input in_item_t x);
        int gap;
        if ($urandom_range(0, 31) == 0)
            tx_burst = !tx_burst;
        gap = tx_burst ? 0 : $urandom_range(0, 14);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_data <= x;
        s_valid <= 1'b1;
        do @(posedge aclk); while (!s_ready);
    endtask

    // stop line runs, when asked for, are broken off before a third dark tick
    task automatic run_random(input int count, input bit stop_runs);
        in_item_t x;
        bit       wide;
        repeat (count) begin
            wide = stop_runs && dark_streak < 2
                   && $urandom_range(0, (dark_streak > 0) ? 1 : 11) == 0;
            x = random_tick(wide, dark_streak < 2);
            dark_streak = ($countones(x.sensor_mask) >= WIDE_DARK) ? dark_streak + 1 : 0;
            send_tick(x);
        end
    endtask

    task automatic drain();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (in_flight != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(posedge aclk);
    endtask

    task automatic program_regs(input logic [CFG_DATA_W-1:0] base, input logic [CFG_DATA_W-1:0] kp,
                                input logic [CFG_DATA_W-1:0] kd, input logic [CFG_DATA_W-1:0] b_mm,
                                input logic [CFG_DATA_W-1:0] arm_mm,
                                input logic [CFG_DATA_W-1:0] thr);
        write_reg(REG_BASE_SPEED, base);
        write_reg(REG_KP, kp);
        write_reg(REG_KD, kd);
        write_reg(REG_B_DISTANCE, b_mm);
        write_reg(REG_ARM_DISTANCE, arm_mm);
        write_reg(REG_BLACK_THR, thr);
        cfg_wr_en <= 1'b0;
    endtask

    initial begin
        aresetn <= 1'b0;
        s_valid <= 1'b0;
        s_data <= '0;
        cfg_wr_en <= 1'b0;
        cfg_index <= '0;
        cfg_wdata <= '0;
        dark_streak = 0;
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // register defaults: lost line before first sighting, deadband edges,
        // odometry limit, clamps, search in every remembered direction
        send_tick(make_tick(8'h00, LINE_LOST, 0, 0));
        send_tick(make_tick(8'hFF, LINE_LOST, -2048, 2047));
        send_tick(make_tick(8'h18, 0, 1200, 1200));
        send_tick(make_tick(8'h0C, DEADBAND, 1201, 1200));
        send_tick(make_tick(8'h30, -DEADBAND, -1200, -1201));
        send_tick(make_tick(8'h60, DEADBAND + 1, 500, -500));
        send_tick(make_tick(8'hC0, 100, 0, 0));
        send_tick(make_tick(8'h00, LINE_LOST, 300, 300));
        send_tick(make_tick(8'h03, -(DEADBAND + 1), 700, 650));
        send_tick(make_tick(8'h01, -100, -300, 900));
        send_tick(make_tick(8'h00, LINE_LOST, 100, 100));
        send_tick(make_tick(8'hAA, -128, 1000, 1000));
        send_tick(make_tick(8'h55, 126, 1000, -1000));
        send_tick(make_tick(8'h0F, 101, 250, 250));
        send_tick(make_tick(8'hF0, -101, 250, 250));
        send_tick(make_tick(8'h18, 5, 600, 600));
        send_tick(make_tick(8'h00, LINE_LOST, 600, 600));
        send_tick(make_tick(8'h7F, -1, -1, -1));
        send_tick(make_tick(8'hFE, 1, 2047, -2048));
        send_tick(make_tick(8'h80, 60, -600, 600));
        drain();

        // top speed, stiff gains, B at once, never armed, threshold zero;
        // upper data bits set to see them dropped
        write_reg(REG_SPARE_A, 16'hFFFF);
        write_reg(REG_SPARE_B, 16'h5A5A);
        program_regs(16'hFCB0, 16'hE710, 16'd10000, 16'd0, 16'hFFFF, 16'hFFF0);
        run_random(100, 1'b1);
        drain();

        // base above the target range, no steering, armed at once, threshold unreachable
        program_regs(16'h07FF, 16'd0, 16'd0, 16'hFFFF, 16'd0, 16'd15);
        run_random(100, 1'b1);
        drain();

        // zero base, largest gain, full bar needed for a stop line
        program_regs(16'd0, 16'h3FFF, 16'd1, 16'd3000, 16'd0, 16'd8);
        run_random(100, 1'b1);
        drain();

        // realistic tuning, broken stop lines, then a real one that latches
        program_regs(16'd800, 16'd150, 16'd300, 16'd20000, 16'd1000, 16'd6);
        run_random(90, 1'b1);
        repeat (DEBOUNCE_TICKS_DEF) send_tick(random_tick(1'b1, 1'b0));
        run_random(15, 1'b0);
        drain();

        // stopped for good: new settings and a B rewrite change nothing but the flag
        program_regs(16'd1200, 16'd60, 16'd100, 16'd0, 16'hFFFF, 16'd9);
        run_random(30, 1'b1);
        drain();

        if (mismatches == 0)
            $display("line_follow_steering_controller regression: pass");
        else
            $display("line_follow_steering_controller regression: fail");
        $finish;
    end

endmodule

### sim.f
src/lfsc_pkg.sv
src/lfsc_steer.sv
src/line_follow_steering_controller.sv
src/lfsc_checker.sv
bench/lfsc_checker.sv
bench/tb.sv
